[sv/cjei_pkg.sv]
// Shared types, constants and saturating arithmetic for the cubic Julia
// escape-time core. No dependencies; imported by every module of the core.
`timescale 1ns / 1ps
`default_nettype none

package cjei_pkg;

    // Word format: signed 48-bit fixed point.
    localparam int WORD_W = 48;
    localparam int PROD_W = 2 * WORD_W;
    localparam int HALF_W = WORD_W / 2;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic        [WORD_W-1:0] uword_t;

    localparam word_t  SMAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t  SMIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam uword_t UMAX = {WORD_W{1'b1}};

    // Iteration and colour coding.
    localparam int           CNT_W          = 10;
    localparam int           COLOR_W        = 14;
    localparam logic [CNT_W-1:0]   MAX_ITER_RESET = 10'd100;
    localparam logic [COLOR_W-1:0] COLOR_SIDE_OFS = 14'd11;
    localparam logic [COLOR_W-1:0] COLOR_NO_ESC   = {COLOR_W{1'b1}};

    // Request to the shared multiplier.
    typedef struct packed {
        logic  start;
        word_t x;
        word_t y;
    } mul_req_t;

    // Response from the shared multiplier: signed and unsigned saturation.
    typedef struct packed {
        logic   done;
        word_t  res_s;
        uword_t res_u;
    } mul_rsp_t;

    // Saturating add or subtract of two words.
    function automatic word_t sat_add(input word_t a, input word_t b, input logic sub);
        logic [WORD_W:0] s;
        word_t           r;
        if (sub) begin
            s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        end else begin
            s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        end
        if (s[WORD_W] != s[WORD_W-1]) begin
            r = s[WORD_W] ? SMIN : SMAX;
        end else begin
            r = s[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/cubic_julia_escape_iteration_core.sv]
// Top level of the cubic Julia escape-time core: coefficient registers,
// step sequencer and result register. Uses cjei_pkg and cjei_mul.
//
// Usage:
//  - Coefficients a, b, the ray coefficient, the escape limit and the
//    iteration cap are to be written over the cfg_* channel only while the
//    core is idle; the core does not enforce this. cfg_ready is always high.
//  - A point enters on the s_* stream (tuser selects a full escape-time run
//    or a single map step) and one result leaves on the m_* stream.
//  - All products go through one shared multiplier, one at a time; one map
//    step is eleven products, nine saturating adds and one check.
//  - One point is in work at a time: s_tready is high only when the sequencer
//    is idle. A finished result waits in the output register, and the next
//    point is accepted meanwhile; if the receiver still stalls when that
//    point completes, the sequencer holds until the register is free.
//  - Reset (aresetn low, synchronous) loads the register defaults, empties
//    the output register and returns the sequencer to idle.
`timescale 1ns / 1ps
`default_nettype none

module cubic_julia_escape_iteration_core
    import cjei_pkg::*;
#(
    parameter int ITER_LIMIT = 1023,
    parameter int FRAC_BITS  = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Configuration write channel.
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [47:0]  cfg_data,
    // Input stream.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,   // start_re[47:0], start_im[95:48]
    input  wire logic         s_tuser,   // op
    // Result stream.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata    // color_code[13:0], escaped[14],
                                         // iteration_count[24:15], ray_side[25],
                                         // next_re[73:26], next_im[121:74], zero
);

    // Register indexes.
    localparam logic [2:0] CFG_A_RE     = 3'd0;
    localparam logic [2:0] CFG_A_IM     = 3'd1;
    localparam logic [2:0] CFG_B_RE     = 3'd2;
    localparam logic [2:0] CFG_B_IM     = 3'd3;
    localparam logic [2:0] CFG_RAY_RE   = 3'd4;
    localparam logic [2:0] CFG_RAY_IM   = 3'd5;
    localparam logic [2:0] CFG_LIMIT    = 3'd6;
    localparam logic [2:0] CFG_MAX_ITER = 3'd7;

    localparam word_t  ONE         = word_t'(64'd1 << FRAC_BITS);
    localparam uword_t LIMIT_RESET = uword_t'(64'd1000 << FRAC_BITS);
    localparam logic [15:0] ITER_CAP = 16'(ITER_LIMIT);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // Micro-steps of one map step, the modulus test and the side test.
    localparam logic [4:0] SP_SQ_RE    = 5'd0;
    localparam logic [4:0] SP_SQ_IM    = 5'd1;
    localparam logic [4:0] SP_CHECK    = 5'd2;
    localparam logic [4:0] SP_RE_IM    = 5'd3;
    localparam logic [4:0] SP_ARE_RE   = 5'd4;
    localparam logic [4:0] SP_AIM_IM   = 5'd5;
    localparam logic [4:0] SP_AIM_RE   = 5'd6;
    localparam logic [4:0] SP_ARE_IM   = 5'd7;
    localparam logic [4:0] SP_T1       = 5'd8;
    localparam logic [4:0] SP_T2       = 5'd9;
    localparam logic [4:0] SP_X3       = 5'd10;
    localparam logic [4:0] SP_T3       = 5'd11;
    localparam logic [4:0] SP_XU       = 5'd12;
    localparam logic [4:0] SP_U        = 5'd13;
    localparam logic [4:0] SP_M8       = 5'd14;
    localparam logic [4:0] SP_M9       = 5'd15;
    localparam logic [4:0] SP_M10      = 5'd16;
    localparam logic [4:0] SP_M11      = 5'd17;
    localparam logic [4:0] SP_XR       = 5'd18;
    localparam logic [4:0] SP_NRE      = 5'd19;
    localparam logic [4:0] SP_NIM      = 5'd20;
    localparam logic [4:0] SP_SIDE_A   = 5'd21;
    localparam logic [4:0] SP_SIDE_B   = 5'd22;
    localparam logic [4:0] SP_SIDE_SUM = 5'd23;

    // Configuration registers.
    word_t             a_re_reg, a_im_reg, b_re_reg, b_im_reg;
    word_t             ray_re_reg, ray_im_reg;
    uword_t            limit_reg;
    logic [CNT_W-1:0]  max_iter_reg;

    // Sequencer and datapath registers.
    logic [1:0]        state_reg;
    logic [4:0]        step_reg;
    logic              op_reg;
    logic [CNT_W-1:0]  i_reg;
    logic [CNT_W-1:0]  cap_reg;
    logic              esc_reg;
    logic              side_reg;
    word_t             re_reg, im_reg;
    word_t             sr_reg, si_reg;
    uword_t            ur_reg, ui_reg;
    word_t             pa_reg, pb_reg, pc_reg, pd_reg, pe_reg;
    word_t             t1_reg, t2_reg, t3_reg, tu_reg, x_reg;

    // Output register.
    logic              m_tvalid_reg;
    logic [127:0]      m_tdata_reg;

    mul_req_t          mul_req;
    mul_rsp_t          mul_rsp;
    logic              is_mul;
    word_t             alu_a, alu_b;
    logic              alu_sub;
    word_t             alu_sum;
    logic [WORD_W:0]   modsq_raw;
    uword_t            modsq;
    logic              chk_stop;
    logic              chk_esc;
    logic              out_free;
    logic [CNT_W-1:0]  cap_next;
    logic [COLOR_W-1:0] color;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_re_reg     <= '0;
            a_im_reg     <= '0;
            b_re_reg     <= '0;
            b_im_reg     <= '0;
            ray_re_reg   <= ONE;
            ray_im_reg   <= '0;
            limit_reg    <= LIMIT_RESET;
            max_iter_reg <= MAX_ITER_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_A_RE:     a_re_reg     <= word_t'(cfg_data);
                CFG_A_IM:     a_im_reg     <= word_t'(cfg_data);
                CFG_B_RE:     b_re_reg     <= word_t'(cfg_data);
                CFG_B_IM:     b_im_reg     <= word_t'(cfg_data);
                CFG_RAY_RE:   ray_re_reg   <= word_t'(cfg_data);
                CFG_RAY_IM:   ray_im_reg   <= word_t'(cfg_data);
                CFG_LIMIT:    limit_reg    <= cfg_data;
                CFG_MAX_ITER: max_iter_reg <= cfg_data[CNT_W-1:0];
                default:      ;
            endcase
        end
    end

    // Iteration cap, clamped to the build limit.
    assign cap_next = ({6'b0, max_iter_reg} > ITER_CAP) ? ITER_CAP[CNT_W-1:0] : max_iter_reg;

    // Operand selection for the shared multiplier.
    always_comb begin
        is_mul    = 1'b1;
        mul_req.x = '0;
        mul_req.y = '0;
        case (step_reg)
            SP_SQ_RE:  begin mul_req.x = re_reg;   mul_req.y = re_reg;     end
            SP_SQ_IM:  begin mul_req.x = im_reg;   mul_req.y = im_reg;     end
            SP_RE_IM:  begin mul_req.x = re_reg;   mul_req.y = im_reg;     end
            SP_ARE_RE: begin mul_req.x = a_re_reg; mul_req.y = re_reg;     end
            SP_AIM_IM: begin mul_req.x = a_im_reg; mul_req.y = im_reg;     end
            SP_AIM_RE: begin mul_req.x = a_im_reg; mul_req.y = re_reg;     end
            SP_ARE_IM: begin mul_req.x = a_re_reg; mul_req.y = im_reg;     end
            SP_M8:     begin mul_req.x = t1_reg;   mul_req.y = t3_reg;     end
            SP_M9:     begin mul_req.x = t2_reg;   mul_req.y = tu_reg;     end
            SP_M10:    begin mul_req.x = t2_reg;   mul_req.y = t3_reg;     end
            SP_M11:    begin mul_req.x = t1_reg;   mul_req.y = tu_reg;     end
            SP_SIDE_A: begin mul_req.x = re_reg;   mul_req.y = ray_im_reg; end
            SP_SIDE_B: begin mul_req.x = im_reg;   mul_req.y = ray_re_reg; end
            default:   is_mul = 1'b0;
        endcase
        mul_req.start = (state_reg == ST_EXEC) && is_mul;
    end

    cjei_mul #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (mul_req),
        .rsp    (mul_rsp)
    );

    // Operand selection for the saturating adder.
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (step_reg)
            SP_T1:       begin alu_a = sr_reg; alu_b = si_reg;   alu_sub = 1'b1; end
            SP_T2:       begin alu_a = pa_reg; alu_b = pa_reg;                   end
            SP_X3:       begin alu_a = pb_reg; alu_b = pc_reg;   alu_sub = 1'b1; end
            SP_T3:       begin alu_a = x_reg;  alu_b = b_re_reg;                 end
            SP_XU:       begin alu_a = pd_reg; alu_b = pe_reg;                   end
            SP_U:        begin alu_a = x_reg;  alu_b = b_im_reg;                 end
            SP_XR:       begin alu_a = pb_reg; alu_b = pc_reg;   alu_sub = 1'b1; end
            SP_NRE:      begin alu_a = x_reg;  alu_b = ONE;                      end
            SP_NIM:      begin alu_a = pd_reg; alu_b = pe_reg;                   end
            SP_SIDE_SUM: begin alu_a = pb_reg; alu_b = pc_reg;                   end
            default:     ;
        endcase
    end

    assign alu_sum = sat_add(alu_a, alu_b, alu_sub);

    // Modulus test on the squares of the current point.
    assign modsq_raw = {1'b0, ur_reg} + {1'b0, ui_reg};
    assign modsq     = modsq_raw[WORD_W] ? UMAX : modsq_raw[WORD_W-1:0];
    assign chk_stop  = !op_reg && (i_reg >= cap_reg);
    assign chk_esc   = !op_reg && !chk_stop && (modsq >= limit_reg);

    // Sequencer control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= SP_SQ_RE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_EXEC;
                        step_reg  <= SP_SQ_RE;
                    end
                end
                ST_EXEC: begin
                    if (is_mul) begin
                        state_reg <= ST_WAIT;
                    end else begin
                        case (step_reg)
                            SP_CHECK: begin
                                if (chk_stop) begin
                                    state_reg <= ST_DONE;
                                end else if (chk_esc) begin
                                    step_reg <= SP_SIDE_A;
                                end else begin
                                    step_reg <= SP_RE_IM;
                                end
                            end
                            SP_NIM: begin
                                if (op_reg) begin
                                    state_reg <= ST_DONE;
                                end else begin
                                    step_reg <= SP_SQ_RE;
                                end
                            end
                            SP_SIDE_SUM: state_reg <= ST_DONE;
                            default:     step_reg  <= step_reg + 5'd1;
                        endcase
                    end
                end
                ST_WAIT: begin
                    if (mul_rsp.done) begin
                        state_reg <= ST_EXEC;
                        step_reg  <= step_reg + 5'd1;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Colour code of an escape-time run.
    always_comb begin
        if (!esc_reg) begin
            color = COLOR_NO_ESC;
        end else begin
            color = COLOR_W'({i_reg, 2'b00}) + (side_reg ? COLOR_SIDE_OFS : '0);
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            op_reg   <= s_tuser;
            re_reg   <= word_t'(s_tdata[47:0]);
            im_reg   <= word_t'(s_tdata[95:48]);
            i_reg    <= '0;
            cap_reg  <= cap_next;
            esc_reg  <= 1'b0;
            side_reg <= 1'b0;
        end
        // Products from the shared multiplier.
        if (state_reg == ST_WAIT && mul_rsp.done) begin
            case (step_reg)
                SP_SQ_RE:  begin sr_reg <= mul_rsp.res_s; ur_reg <= mul_rsp.res_u; end
                SP_SQ_IM:  begin si_reg <= mul_rsp.res_s; ui_reg <= mul_rsp.res_u; end
                SP_RE_IM:  pa_reg <= mul_rsp.res_s;
                SP_ARE_RE, SP_M8,  SP_SIDE_A: pb_reg <= mul_rsp.res_s;
                SP_AIM_IM, SP_M9,  SP_SIDE_B: pc_reg <= mul_rsp.res_s;
                SP_AIM_RE, SP_M10: pd_reg <= mul_rsp.res_s;
                SP_ARE_IM, SP_M11: pe_reg <= mul_rsp.res_s;
                default:   ;
            endcase
        end
        // Sums and test results.
        if (state_reg == ST_EXEC) begin
            case (step_reg)
                SP_CHECK:    esc_reg <= chk_esc;
                SP_T1:       t1_reg  <= alu_sum;
                SP_T2:       t2_reg  <= alu_sum;
                SP_X3, SP_XU, SP_XR: x_reg <= alu_sum;
                SP_T3:       t3_reg  <= alu_sum;
                SP_U:        tu_reg  <= alu_sum;
                SP_NRE:      re_reg  <= alu_sum;
                SP_NIM: begin
                    im_reg <= alu_sum;
                    if (!op_reg) begin
                        i_reg <= i_reg + 10'd1;
                    end
                end
                SP_SIDE_SUM: side_reg <= alu_sum[WORD_W-1];
                default:     ;
            endcase
        end
        // Result packing into the output register.
        if (state_reg == ST_DONE && out_free) begin
            if (op_reg) begin
                m_tdata_reg <= {6'b0, im_reg, re_reg, 1'b0, {CNT_W{1'b0}}, 1'b0,
                                {COLOR_W{1'b0}}};
            end else begin
                m_tdata_reg <= {6'b0, {WORD_W{1'b0}}, {WORD_W{1'b0}}, side_reg, i_reg,
                                esc_reg, color};
            end
        end
    end

    // A transfer in always starts work in the sequencer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted point did not start the sequencer");

    // Multiplier results only arrive while the sequencer waits for them.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.done |-> (state_reg == ST_WAIT))
        else $error("multiplier result outside of a wait step");

    // A new result is only loaded from the completion state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result register loaded outside completion");

    // The step count never passes the cap while a point is in work.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (i_reg <= cap_reg))
        else $error("iteration count exceeded the cap");

endmodule

`default_nettype wire

[sv/cjei_mul.sv]
// Shared fixed-point multiplier: 48x48 magnitudes built from four 24x24
// partial products, then floor rounding and saturation. Uses cjei_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cjei_mul
    import cjei_pkg::*;
#(
    parameter int FRAC_BITS = 32
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire mul_req_t req,
    output mul_rsp_t      rsp
);

    localparam int QW = PROD_W - FRAC_BITS;

    // Phase codes: four partial products, one drain and one rounding step.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_PP0   = 3'd1;
    localparam logic [2:0] PH_PP1   = 3'd2;
    localparam logic [2:0] PH_PP2   = 3'd3;
    localparam logic [2:0] PH_PP3   = 3'd4;
    localparam logic [2:0] PH_DRAIN = 3'd5;
    localparam logic [2:0] PH_ROUND = 3'd6;

    logic [2:0]        ph_reg;
    logic              neg_reg;
    uword_t            ux_reg;
    uword_t            uy_reg;
    logic [WORD_W-1:0] pp_reg;
    logic [PROD_W-1:0] acc_reg;
    logic              done_reg;
    word_t             res_s_reg;
    uword_t            res_u_reg;

    logic [HALF_W-1:0] mx;
    logic [HALF_W-1:0] my;
    logic [WORD_W-1:0] pp;
    logic [PROD_W-1:0] pp_shifted;
    logic [QW-1:0]     q;
    logic [QW-1:0]     qr;
    logic              rem_nz;
    word_t             sat_s;
    uword_t            sat_u;

    // Phase sequencing.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg   <= PH_IDLE;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (ph_reg == PH_ROUND);
            if (ph_reg == PH_IDLE) begin
                if (req.start) begin
                    ph_reg <= PH_PP0;
                end
            end else if (ph_reg == PH_ROUND) begin
                ph_reg <= PH_IDLE;
            end else begin
                ph_reg <= ph_reg + 3'd1;
            end
        end
    end

    // Operand halves for the partial product of this phase.
    always_comb begin
        case (ph_reg)
            PH_PP0:  begin mx = ux_reg[HALF_W-1:0];      my = uy_reg[HALF_W-1:0];      end
            PH_PP1:  begin mx = ux_reg[HALF_W-1:0];      my = uy_reg[WORD_W-1:HALF_W]; end
            PH_PP2:  begin mx = ux_reg[WORD_W-1:HALF_W]; my = uy_reg[HALF_W-1:0];      end
            PH_PP3:  begin mx = ux_reg[WORD_W-1:HALF_W]; my = uy_reg[WORD_W-1:HALF_W]; end
            default: begin mx = '0;                      my = '0;                      end
        endcase
    end

    assign pp = mx * my;

    // Alignment of the partial product registered in the previous phase.
    always_comb begin
        case (ph_reg)
            PH_PP1:   pp_shifted = PROD_W'(pp_reg);
            PH_PP2:   pp_shifted = PROD_W'(pp_reg) << HALF_W;
            PH_PP3:   pp_shifted = PROD_W'(pp_reg) << HALF_W;
            PH_DRAIN: pp_shifted = PROD_W'(pp_reg) << WORD_W;
            default:  pp_shifted = '0;
        endcase
    end

    // Floor of the scaled product: a negative result with a remainder rounds down.
    assign q      = acc_reg[PROD_W-1:FRAC_BITS];
    assign rem_nz = |acc_reg[FRAC_BITS-1:0];
    assign qr     = q + QW'(neg_reg && rem_nz);

    always_comb begin
        if (!neg_reg) begin
            sat_s = (|qr[QW-1:WORD_W-1]) ? SMAX : word_t'(qr[WORD_W-1:0]);
        end else if ((|qr[QW-1:WORD_W]) || (qr[WORD_W-1] && (|qr[WORD_W-2:0]))) begin
            sat_s = SMIN;
        end else begin
            sat_s = word_t'(~qr[WORD_W-1:0] + uword_t'(1));
        end
        sat_u = (|qr[QW-1:WORD_W]) ? UMAX : qr[WORD_W-1:0];
    end

    // Operand capture, accumulation and result registers.
    always_ff @(posedge aclk) begin
        if (ph_reg == PH_IDLE && req.start) begin
            neg_reg <= req.x[WORD_W-1] ^ req.y[WORD_W-1];
            ux_reg  <= req.x[WORD_W-1] ? (~uword_t'(req.x) + uword_t'(1)) : uword_t'(req.x);
            uy_reg  <= req.y[WORD_W-1] ? (~uword_t'(req.y) + uword_t'(1)) : uword_t'(req.y);
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_reg + pp_shifted;
        end
        pp_reg <= pp;
        if (ph_reg == PH_ROUND) begin
            res_s_reg <= sat_s;
            res_u_reg <= sat_u;
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.res_s = res_s_reg;
    assign rsp.res_u = res_u_reg;

endmodule

`default_nettype wire

[bench/tb_cubic_julia_escape_iteration_core.sv]
// Self-checking bench for the cubic Julia escape-time core: a directed table of points,
// then randomised phases, checked against fixed expectations or a predictor kept in this file.
// Depends on cjei_pkg and cubic_julia_escape_iteration_core.
`timescale 1ns / 1ps

module tb_cubic_julia_escape_iteration_core;
    import cjei_pkg::*;

    localparam int     ITER_LIMIT   = 1023;
    localparam int     FRAC_BITS    = 32;
    localparam longint LIMIT_CYCLES = 3_000_000;
    localparam int     DRAIN_CYCLES = 300;
    localparam int     PHASES       = 6;
    localparam int     PHASE_POINTS = 20;
    localparam longint W_MAX        = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint W_MIN        = -W_MAX - 1;
    localparam longint U_MAX        = 64'sh0000_FFFF_FFFF_FFFF;
    localparam longint ONE_Q        = 64'sh0000_0001_0000_0000;
    localparam word_t  ONE_W        = word_t'(ONE_Q);

    typedef enum logic {OP_ESCAPE = 1'b0, OP_STEP = 1'b1} op_e;

    typedef enum logic [2:0] {
        REG_A_RE, REG_A_IM, REG_B_RE, REG_B_IM,
        REG_RAY_RE, REG_RAY_IM, REG_ESC_LIMIT, REG_MAX_ITER
    } cfg_reg_e;

    typedef enum logic [1:0] {ROW_WRITE, ROW_POINT, ROW_KNOWN} row_kind_e;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_STARVED, RX_PATTERN} rx_mode_e;

    typedef struct packed {
        logic signed [13:0] color;
        logic               escaped;
        logic [9:0]         count;
        logic               side;
        word_t              next_re;
        word_t              next_im;
    } result_t;

    typedef struct packed {
        row_kind_e   kind;
        cfg_reg_e    reg_idx;
        logic [47:0] value;
        op_e         op;
        word_t       re;
        word_t       im;
        result_t     want;
    } stim_row_t;

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [2:0]    cfg_index = '0;
    logic [47:0]   cfg_data  = '0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [95:0]   s_tdata   = '0;
    logic          s_tuser   = 1'b0;
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [127:0]  m_tdata;

    // Bench copy of the coefficient registers, starting from their reset values.
    longint        coef_a_re = 0;
    longint        coef_a_im = 0;
    longint        coef_b_re = 0;
    longint        coef_b_im = 0;
    longint        ray_re_q  = ONE_Q;
    longint        ray_im_q  = 0;
    longint        esc_limit = 1000 * ONE_Q;
    int unsigned   iter_cap  = 100;

    result_t       pending_results[$];
    stim_row_t     plan[$];
    int            mismatches  = 0;
    longint        cycles      = 0;
    int            burst_left  = 0;
    rx_mode_e      rx_mode     = RX_OPEN;
    int            rx_left     = 0;
    logic [7:0]    rx_pattern  = 8'b1011_0010;
    result_t       seen_result;
    result_t       due_result;

    always #5 aclk = ~aclk;

    cubic_julia_escape_iteration_core #(
        .ITER_LIMIT (ITER_LIMIT),
        .FRAC_BITS  (FRAC_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Saturating fixed-point arithmetic on 48-bit words held in longints.
    function automatic longint clamp_word(longint v);
        if (v > W_MAX) return W_MAX;
        if (v < W_MIN) return W_MIN;
        return v;
    endfunction

    // Product rounded towards minus infinity, then saturated to the signed word.
    function automatic longint fx_mul(longint x, longint y);
        logic signed [127:0] p;
        p = x;
        p = (p * y) >>> FRAC_BITS;
        if (p > W_MAX) return W_MAX;
        if (p < W_MIN) return W_MIN;
        return longint'(p);
    endfunction

    // Square saturated to the unsigned word range, for the modulus test.
    function automatic longint fx_sq_mag(longint x);
        logic signed [127:0] p;
        p = x;
        p = (p * p) >>> FRAC_BITS;
        if (p > U_MAX) return U_MAX;
        return longint'(p);
    endfunction

    function automatic longint modulus_sq(longint re, longint im);
        longint s;
        s = fx_sq_mag(re) + fx_sq_mag(im);
        return (s > U_MAX) ? U_MAX : s;
    endfunction

    // One application of z -> a z^3 + b z^2 + 1, every operation saturated in order.
    function automatic void julia_step(inout longint re, inout longint im);
        longint t1, t2, t3, u;
        t1 = clamp_word(fx_mul(re, re) - fx_mul(im, im));
        t2 = clamp_word(2 * fx_mul(re, im));
        t3 = clamp_word(clamp_word(fx_mul(coef_a_re, re) - fx_mul(coef_a_im, im)) + coef_b_re);
        u  = clamp_word(clamp_word(fx_mul(coef_a_im, re) + fx_mul(coef_a_re, im)) + coef_b_im);
        re = clamp_word(clamp_word(fx_mul(t1, t3) - fx_mul(t2, u)) + ONE_Q);
        im = clamp_word(fx_mul(t2, t3) + fx_mul(t1, u));
    endfunction

    // Expected colour, count and side for an escape run, or the next point for a single step.
    function automatic result_t predict_point(op_e op, word_t sre, word_t sim);
        longint      re, im, side_im;
        int unsigned cap, n;
        result_t     r;
        r  = '0;
        re = sre;
        im = sim;
        n  = 0;
        if (op == OP_STEP) begin
            julia_step(re, im);
            r.next_re = re[47:0];
            r.next_im = im[47:0];
        end else begin
            cap = (iter_cap > ITER_LIMIT) ? ITER_LIMIT : iter_cap;
            while (n < cap && modulus_sq(re, im) < esc_limit) begin
                julia_step(re, im);
                n++;
            end
            r.count = n[9:0];
            if (n >= cap) begin
                r.color = '1;
            end else begin
                side_im   = clamp_word(fx_mul(re, ray_im_q) + fx_mul(im, ray_re_q));
                r.escaped = 1'b1;
                r.side    = (side_im < 0);
                r.color   = 14'(n * 4 + (r.side ? 11 : 0));
            end
        end
        return r;
    endfunction

    function automatic result_t mk_result(int color, logic esc, int count, logic side,
                                          word_t nre, word_t nim);
        result_t r;
        r.color   = color[13:0];
        r.escaped = esc;
        r.count   = count[9:0];
        r.side    = side;
        r.next_re = nre;
        r.next_im = nim;
        return r;
    endfunction

    function automatic string show(result_t r);
        return $sformatf("colour %0d escaped %0b count %0d side %0b next %h %h",
                         $signed(r.color), r.escaped, r.count, r.side, r.next_re, r.next_im);
    endfunction

    // Signed random word spread over roughly +/- 2^bits.
    function automatic word_t rand_fix(int bits);
        longint v;
        v = {$urandom, $urandom};
        v = v >>> (63 - bits);
        return v[47:0];
    endfunction

    function automatic void stage_write(cfg_reg_e idx, logic [47:0] val);
        stim_row_t row;
        row         = '0;
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.value   = val;
        plan.push_back(row);
    endfunction

    function automatic void stage_point(op_e op, word_t re, word_t im, logic known,
                                        result_t want);
        stim_row_t row;
        row      = '0;
        row.kind = known ? ROW_KNOWN : ROW_POINT;
        row.op   = op;
        row.re   = re;
        row.im   = im;
        row.want = want;
        plan.push_back(row);
    endfunction

    // One register write transfer; the bench copy follows the written value.
    task automatic write_reg(cfg_reg_e idx, logic [47:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_A_RE:      coef_a_re = $signed(val);
            REG_A_IM:      coef_a_im = $signed(val);
            REG_B_RE:      coef_b_re = $signed(val);
            REG_B_IM:      coef_b_im = $signed(val);
            REG_RAY_RE:    ray_re_q  = $signed(val);
            REG_RAY_IM:    ray_im_q  = $signed(val);
            REG_ESC_LIMIT: esc_limit = val;
            default:       iter_cap  = val[9:0];
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Hold the input stream idle until every outstanding result has been seen.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    // Offer one point in bursts with random gaps; the expectation is queued on the transfer.
    task automatic put_point(op_e op, word_t re, word_t im, logic known, result_t want);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 12);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 30 : $urandom_range(1, 6);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {im, re};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(known ? want : predict_point(op, re, im));
    endtask

    // Receiver back-pressure: open stretches, coin tosses, long stalls and a rotating pattern.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_e'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 300);
        end
        rx_left--;
        rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
        case (rx_mode)
            RX_OPEN:    m_tready = 1'b1;
            RX_COIN:    m_tready = 1'($urandom_range(0, 1));
            RX_STARVED: m_tready = ($urandom_range(0, 9) == 0);
            default:    m_tready = rx_pattern[0];
        endcase
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_result = mk_result(m_tdata[13:0], m_tdata[14], m_tdata[24:15], m_tdata[25],
                                    m_tdata[73:26], m_tdata[121:74]);
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t ns: result with none expected: %s", $time, show(seen_result));
            end else begin
                due_result = pending_results.pop_front();
                if (seen_result !== due_result) begin
                    mismatches++;
                    $display("%0t ns: result mismatch, expected %s", $time, show(due_result));
                    $display("%0t ns:                   actual %s", $time, show(seen_result));
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        stim_row_t   row;
        logic [47:0] cfg_vals [8];
        int unsigned pause_at;
        op_e         op;
        logic        wide;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset coefficients: a = b = 0 sends every point to 1.0, so results are plain.
        stage_point(OP_STEP, 0, 0, 1'b1, mk_result(0, 0, 0, 0, ONE_W, 0));
        stage_point(OP_STEP, SMAX, SMIN, 1'b1, mk_result(0, 0, 0, 0, ONE_W, 0));
        stage_point(OP_STEP, SMIN, SMAX, 1'b1, mk_result(0, 0, 0, 0, ONE_W, 0));
        stage_point(OP_ESCAPE, 0, 0, 1'b1, mk_result(-1, 0, 100, 0, 0, 0));
        stage_point(OP_ESCAPE, SMAX, 0, 1'b1, mk_result(0, 1, 0, 0, 0, 0));
        stage_point(OP_ESCAPE, 0, SMIN, 1'b1, mk_result(11, 1, 0, 1, 0, 0));
        stage_point(OP_ESCAPE, 0, SMAX, 1'b1, mk_result(0, 1, 0, 0, 0, 0));
        stage_point(OP_ESCAPE, SMIN, SMIN, 1'b1, mk_result(11, 1, 0, 1, 0, 0));
        stage_point(OP_ESCAPE, 0, word_t'(-32 * ONE_Q), 1'b1, mk_result(11, 1, 0, 1, 0, 0));
        // A zero cap reports no escape even for a point far outside the limit.
        stage_write(REG_MAX_ITER, 0);
        stage_point(OP_ESCAPE, SMAX, SMAX, 1'b1, mk_result(-1, 0, 0, 0, 0, 0));
        stage_point(OP_ESCAPE, 0, 0, 1'b1, mk_result(-1, 0, 0, 0, 0, 0));
        stage_point(OP_STEP, -ONE_W, ONE_W, 1'b1, mk_result(0, 0, 0, 0, ONE_W, 0));
        // z -> z^3 + 1 at the largest cap: short escapes, side test after steps, saturation.
        stage_write(REG_A_RE, ONE_W);
        stage_write(REG_MAX_ITER, ITER_LIMIT);
        stage_write(REG_ESC_LIMIT, 48'(4 * ONE_Q));
        stage_point(OP_ESCAPE, 0, 0, 1'b0, '0);
        stage_point(OP_ESCAPE, -ONE_W, 0, 1'b0, '0);
        stage_point(OP_ESCAPE, ONE_W, ONE_W, 1'b0, '0);
        stage_point(OP_ESCAPE, ONE_W, -ONE_W, 1'b0, '0);
        stage_point(OP_STEP, ONE_W, ONE_W, 1'b0, '0);
        stage_point(OP_STEP, SMAX, SMAX, 1'b0, '0);
        stage_point(OP_STEP, SMIN, -ONE_W, 1'b0, '0);
        // A zero escape limit makes every point escape at once.
        stage_write(REG_ESC_LIMIT, 0);
        stage_point(OP_ESCAPE, 0, -ONE_W, 1'b1, mk_result(11, 1, 0, 1, 0, 0));

        foreach (plan[i]) begin
            row = plan[i];
            if (row.kind == ROW_WRITE) begin
                wait_idle();
                write_reg(row.reg_idx, row.value);
            end else begin
                put_point(row.op, row.re, row.im, row.kind == ROW_KNOWN, row.want);
            end
        end

        // Random phases, each with a fresh register setting written while idle.
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            for (int r = 0; r < 6; r++) cfg_vals[r] = rand_fix(r < 2 ? 33 : 32);
            cfg_vals[REG_ESC_LIMIT] = 48'(ONE_Q * $urandom_range(1, 2000) + $urandom);
            cfg_vals[REG_MAX_ITER]  = $urandom_range(1, 12);
            if (ph == 0) begin
                // Coefficients at the word extremes push the map steps towards saturation.
                cfg_vals[REG_A_RE]      = SMAX;
                cfg_vals[REG_A_IM]      = SMIN;
                cfg_vals[REG_B_RE]      = SMIN;
                cfg_vals[REG_B_IM]      = SMAX;
                cfg_vals[REG_RAY_RE]    = SMIN;
                cfg_vals[REG_RAY_IM]    = SMAX;
                cfg_vals[REG_ESC_LIMIT] = UMAX;
                cfg_vals[REG_MAX_ITER]  = $urandom_range(1, 6);
            end else if (ph == 3) begin
                cfg_vals[REG_ESC_LIMIT] = $urandom;
            end else if (ph == PHASES - 1) begin
                cfg_vals[REG_ESC_LIMIT] = 0;
                cfg_vals[REG_MAX_ITER]  = ITER_LIMIT;
            end
            for (int r = 0; r < 8; r++) write_reg(cfg_reg_e'(r), cfg_vals[r]);

            pause_at = $urandom_range(4, 16);
            for (int k = 0; k < PHASE_POINTS; k++) begin
                if (k == pause_at) wait_idle();
                op   = ($urandom_range(0, 99) < 65) ? OP_ESCAPE : OP_STEP;
                wide = ($urandom_range(0, 3) == 0);
                put_point(op, rand_fix(wide ? 47 : $urandom_range(30, 35)),
                          rand_fix(wide ? 47 : $urandom_range(30, 35)), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[cubic_julia_escape_iteration_core.f]
sv/cjei_pkg.sv
sv/cjei_mul.sv
sv/cubic_julia_escape_iteration_core.sv
bench/tb_cubic_julia_escape_iteration_core.sv
